@@ hdl/assert_macros.svh @@
// Assertion macros shared by the rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define TDR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define TDR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/tdr_pkg.sv @@
// Shared types, constants and helpers of the triangle depth rasterizer.
`default_nettype none
package tdr_pkg;

    localparam int MAP_WIDTH  = 256;
    localparam int MAP_HEIGHT = 256;
    localparam int MAP_SIZE   = MAP_WIDTH * MAP_HEIGHT;
    localparam int ADDR_W     = $clog2(MAP_SIZE);
    localparam int XW         = $clog2(MAP_WIDTH);
    localparam int YW         = $clog2(MAP_HEIGHT);
    localparam int CFG_W      = 9;

    localparam logic signed [31:0] DEPTH_FAR = 32'sh7FFF_FFFF;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic [1:0] VTX_LAST = 2'd2;

    // Shared unit widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 52;
    localparam int CRD_W   = 24;
    localparam int EDG_W   = 25;
    localparam int DIV_N_W = 48;
    localparam int DIV_D_W = 52;
    localparam int DIV_S_W = 6;
    localparam int WGT_W   = 17;

    localparam logic [DIV_S_W-1:0] DIV_STEPS_NDC  = DIV_S_W'(DIV_N_W);
    localparam logic [DIV_S_W-1:0] DIV_STEPS_FRAC = DIV_S_W'(16);

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] clip_x;
        logic signed [31:0] clip_y;
        logic signed [31:0] clip_z;
        logic signed [31:0] clip_w;
        logic [7:0]         pixel_x;
        logic [7:0]         pixel_y;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] depth_read;
        logic [16:0]        pixels_written;
        logic               triangle_culled;
        logic               triangle_done;
    } t_out_word;

    typedef struct packed {
        logic               go;
        logic [DIV_S_W-1:0] steps;
    } t_div_req;

    // Saturate a signed quotient to the x/y guard band [-2^22, 2^22-1].
    function automatic logic signed [31:0] sat_guard(input logic neg,
                                                     input logic [DIV_N_W-1:0] mag);
        if (neg) begin
            if (mag > DIV_N_W'(4194304)) return -32'sd4194304;
            else return 32'(-$signed({1'b0, mag}));
        end else begin
            if (mag > DIV_N_W'(4194303)) return 32'sd4194303;
            else return 32'(mag);
        end
    endfunction

    // Saturate a signed quotient to the 32-bit range.
    function automatic logic signed [31:0] sat_word(input logic neg,
                                                    input logic [DIV_N_W-1:0] mag);
        if (neg) begin
            if (mag > DIV_N_W'(33'h1_0000_0000 >> 1)) return 32'sh8000_0000;
            else return 32'(-$signed({1'b0, mag}));
        end else begin
            if (mag > DIV_N_W'(32'h7FFF_FFFF)) return 32'sh7FFF_FFFF;
            else return 32'(mag);
        end
    endfunction

endpackage
`default_nettype wire

@@ hdl/tdr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/tdr_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, shared by all divides.
`default_nettype none
`include "assert_macros.svh"
module tdr_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire tdr_pkg::t_div_req           i_req,
    input  wire logic [tdr_pkg::DIV_D_W-1:0] i_rem0,
    input  wire logic [tdr_pkg::DIV_N_W-1:0] i_num,
    input  wire logic [tdr_pkg::DIV_D_W-1:0] i_den,
    output logic                             o_done,
    output logic [tdr_pkg::DIV_N_W-1:0]      o_quot
);

    logic [tdr_pkg::DIV_D_W-1:0] r_rem;
    logic [tdr_pkg::DIV_D_W-1:0] r_den;
    logic [tdr_pkg::DIV_N_W-1:0] r_num;
    logic [tdr_pkg::DIV_N_W-1:0] r_quot;
    logic [tdr_pkg::DIV_S_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [tdr_pkg::DIV_D_W:0] trial;
    logic                      fits;

    // Bring down the next numerator bit and try one subtract.
    assign trial = {r_rem, r_num[tdr_pkg::DIV_N_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_rem  <= i_rem0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_quot <= '0;
                r_cnt  <= i_req.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? tdr_pkg::DIV_D_W'(trial - {1'b0, r_den})
                               : tdr_pkg::DIV_D_W'(trial);
                r_num  <= {r_num[tdr_pkg::DIV_N_W-2:0], 1'b0};
                r_quot <= {r_quot[tdr_pkg::DIV_N_W-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == tdr_pkg::DIV_S_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    `TDR_ASSERT_NEXT(a_div_go_not_done, i_req.go, !r_done)
    `TDR_ASSERT_IMPL(a_div_done_idle, r_done, !r_busy)
    `TDR_ASSERT_IMPL(a_div_rem_below, r_busy, r_rem < r_den)

endmodule
`default_nettype wire

@@ hdl/tdr_mul.sv @@
// Shared signed multiplier with a registered product.
`default_nettype none
module tdr_mul (
    input  wire logic                               i_clk,
    input  wire logic signed [tdr_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [tdr_pkg::MUL_B_W-1:0] i_b,
    output logic signed      [tdr_pkg::MUL_P_W-1:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= tdr_pkg::MUL_P_W'(i_a) * tdr_pkg::MUL_P_W'(i_b);
    end

endmodule
`default_nettype wire

@@ hdl/triangle_depth_rasterizer_top.sv @@
// Top level: sequencer of the shadow-map depth rasterizer.
//
//  channel  direction  handshake                 data
//  input    in         i_in_valid / o_in_ready   i_in_word  (t_in_word)
//  output   out        o_out_valid / i_out_ready o_out_word (t_out_word)
//  config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One word at a time. A clear sweeps all MAP_SIZE words to far. A triangle runs
// nine perspective divides, then an edge test for each pixel of its clamped
// bounding box and at most two weight divides per covered pixel, the divides all
// on the single radix-2 divider. After reset the map is swept to far with
// o_in_ready low.
// Results wait in an output register; config writes are always taken.
`default_nettype none
`include "assert_macros.svh"
module triangle_depth_rasterizer_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire tdr_pkg::t_in_word         i_in_word,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output tdr_pkg::t_out_word             o_out_word,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic                      i_cfg_index,
    input  wire logic [tdr_pkg::CFG_W-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD, S_RD2,
        S_XF_DIV, S_XF_WAIT, S_XF_MUL, S_XF_SCL,
        S_BOX, S_DET1, S_DET2, S_DET3,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_TEST,
        S_W0, S_W0_WAIT, S_W1, S_W1_WAIT,
        S_Z1, S_Z2, S_Z3, S_Z4, S_NEXT, S_EMIT
    } t_state;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    t_state r_state;

    logic [tdr_pkg::CFG_W-1:0]     r_cfg_w, r_cfg_h;
    logic [1:0]                    r_vcnt;
    logic signed [31:0]            r_vtx [3][4];
    logic [1:0]                    r_k, r_c;
    logic signed [31:0]            r_ndc;
    logic signed [31:0]            r_nz [3];
    logic signed [tdr_pkg::CRD_W-1:0] r_sx [3];
    logic signed [tdr_pkg::CRD_W-1:0] r_sy [3];
    logic [tdr_pkg::XW-1:0]        r_wm1, r_minx, r_maxx, r_px;
    logic [tdr_pkg::YW-1:0]        r_hm1, r_miny, r_maxy, r_py;
    logic                          r_box_empty;
    logic signed [tdr_pkg::EDG_W-1:0] r_e0a, r_e0b, r_e1a, r_e1b;
    logic signed [tdr_pkg::ACC_W-1:0] r_acc, r_n0, r_n1;
    logic [tdr_pkg::ACC_W-1:0]     r_dabs;
    logic                          r_dneg;
    logic [tdr_pkg::WGT_W-1:0]     r_w0, r_w1;
    logic [16:0]                   r_count;
    logic [tdr_pkg::ADDR_W-1:0]    r_clr, r_rd_addr;
    logic                          r_clr_item;
    tdr_pkg::t_out_word            r_res, r_out;
    logic                          r_out_valid;

    // Shared units
    logic signed [tdr_pkg::MUL_A_W-1:0] mul_a;
    logic signed [tdr_pkg::MUL_B_W-1:0] mul_b;
    logic signed [tdr_pkg::MUL_P_W-1:0] mul_p;
    tdr_pkg::t_div_req                  div_req;
    logic [tdr_pkg::DIV_D_W-1:0]        div_rem0, div_den;
    logic [tdr_pkg::DIV_N_W-1:0]        div_num, div_quot;
    logic                               div_done;

    logic                          ram_we, ram_re;
    logic [tdr_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [31:0]                   ram_wdata, ram_rdata;

    // Datapath helpers
    logic                          in_acc;
    logic signed [31:0]            vrow [4];
    logic signed [31:0]            comp;
    logic [31:0]                   cmag;
    logic [tdr_pkg::ADDR_W-1:0]    pix_addr;
    logic signed [tdr_pkg::EDG_W-1:0] ppx, ppy;
    logic signed [tdr_pkg::ACC_W-1:0] sum, n0s, n1s, n2;
    logic [tdr_pkg::WGT_W-1:0]     w2;
    logic signed [31:0]            depth;
    logic                          depth_less;
    logic                          w0_full, w1_full;
    logic signed [tdr_pkg::CRD_W-1:0] mnx, mxx, mny, mxy;
    logic signed [tdr_pkg::EDG_W-1:0] lox, hix, loy, hiy;
    logic [tdr_pkg::CFG_W-1:0]     wc, hc;
    logic                          culled, rd_inside;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign vrow = r_vtx[r_k];
    assign comp = vrow[r_c];
    assign cmag = comp[31] ? (~comp + 32'd1) : comp;

    assign pix_addr = tdr_pkg::ADDR_W'(32'(r_py) * tdr_pkg::MAP_WIDTH + 32'(r_px));
    assign ppx = tdr_pkg::EDG_W'($signed({1'b0, r_px, 8'h00})) - tdr_pkg::EDG_W'(r_sx[2]);
    assign ppy = tdr_pkg::EDG_W'($signed({1'b0, r_py, 8'h00})) - tdr_pkg::EDG_W'(r_sy[2]);

    assign sum   = r_acc + tdr_pkg::ACC_W'(mul_p);
    assign depth = sum[47:16];
    assign depth_less = depth < $signed(ram_rdata);

    assign n0s = r_dneg ? -r_n0 : r_n0;
    assign n1s = r_dneg ? -r_n1 : r_n1;
    assign n2  = $signed(r_dabs) - n0s - n1s;
    assign w0_full = $unsigned(r_n0) >= r_dabs;
    assign w1_full = $unsigned(r_n1) >= r_dabs;
    assign w2 = tdr_pkg::WGT_W'(17'h1_0000 - r_w0 - r_w1);

    // Clamp the active size to [1, MAP_*]
    always_comb begin
        wc = i_cfg_data;
        if (r_cfg_w == '0) wc = tdr_pkg::CFG_W'(1);
        else if (32'(r_cfg_w) > tdr_pkg::MAP_WIDTH) wc = tdr_pkg::CFG_W'(tdr_pkg::MAP_WIDTH);
        else wc = r_cfg_w;
        if (r_cfg_h == '0) hc = tdr_pkg::CFG_W'(1);
        else if (32'(r_cfg_h) > tdr_pkg::MAP_HEIGHT) hc = tdr_pkg::CFG_W'(tdr_pkg::MAP_HEIGHT);
        else hc = r_cfg_h;
    end

    assign culled = (r_vtx[0][3] <= 32'sd0) || (r_vtx[1][3] <= 32'sd0)
                 || (i_in_word.clip_w <= 32'sd0);
    assign rd_inside = (32'(i_in_word.pixel_x) < tdr_pkg::MAP_WIDTH)
                    && (32'(i_in_word.pixel_y) < tdr_pkg::MAP_HEIGHT);

    // Bounding box in pixels, clamped to the active map
    always_comb begin
        mnx = r_sx[0]; mxx = r_sx[0]; mny = r_sy[0]; mxy = r_sy[0];
        for (int i = 1; i < 3; i++) begin
            if (r_sx[i] < mnx) mnx = r_sx[i];
            if (r_sx[i] > mxx) mxx = r_sx[i];
            if (r_sy[i] < mny) mny = r_sy[i];
            if (r_sy[i] > mxy) mxy = r_sy[i];
        end
        lox = tdr_pkg::EDG_W'(mnx >>> 8);
        hix = (tdr_pkg::EDG_W'(mxx) + tdr_pkg::EDG_W'(255)) >>> 8;
        loy = tdr_pkg::EDG_W'(mny >>> 8);
        hiy = (tdr_pkg::EDG_W'(mxy) + tdr_pkg::EDG_W'(255)) >>> 8;
        if (lox < 0) lox = '0;
        if (loy < 0) loy = '0;
        if (hix > $signed({1'b0, r_wm1})) hix = tdr_pkg::EDG_W'({1'b0, r_wm1});
        if (hiy > $signed({1'b0, r_hm1})) hiy = tdr_pkg::EDG_W'({1'b0, r_hm1});
    end

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_XF_MUL: begin
                if (r_c == COMP_X) begin
                    mul_a = tdr_pkg::MUL_A_W'(r_ndc) + tdr_pkg::MUL_A_W'(65536);
                    mul_b = tdr_pkg::MUL_B_W'({1'b0, r_wm1});
                end else begin
                    mul_a = tdr_pkg::MUL_A_W'(65536) - tdr_pkg::MUL_A_W'(r_ndc);
                    mul_b = tdr_pkg::MUL_B_W'({1'b0, r_hm1});
                end
            end
            S_DET1: begin
                mul_a = tdr_pkg::MUL_A_W'(r_e0a);
                mul_b = tdr_pkg::MUL_B_W'(r_e1b);
            end
            S_DET2: begin
                mul_a = tdr_pkg::MUL_A_W'(r_e0b);
                mul_b = -tdr_pkg::MUL_B_W'(r_e1a);
            end
            S_P1: begin
                mul_a = tdr_pkg::MUL_A_W'(r_e0a);
                mul_b = tdr_pkg::MUL_B_W'(ppx);
            end
            S_P2: begin
                mul_a = tdr_pkg::MUL_A_W'(r_e0b);
                mul_b = tdr_pkg::MUL_B_W'(ppy);
            end
            S_P3: begin
                mul_a = tdr_pkg::MUL_A_W'(r_e1a);
                mul_b = tdr_pkg::MUL_B_W'(ppx);
            end
            S_P4: begin
                mul_a = tdr_pkg::MUL_A_W'(r_e1b);
                mul_b = tdr_pkg::MUL_B_W'(ppy);
            end
            S_Z1: begin
                mul_a = tdr_pkg::MUL_A_W'(r_nz[0]);
                mul_b = tdr_pkg::MUL_B_W'({1'b0, r_w0});
            end
            S_Z2: begin
                mul_a = tdr_pkg::MUL_A_W'(r_nz[1]);
                mul_b = tdr_pkg::MUL_B_W'({1'b0, r_w1});
            end
            S_Z3: begin
                mul_a = tdr_pkg::MUL_A_W'(r_nz[2]);
                mul_b = tdr_pkg::MUL_B_W'({1'b0, w2});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider request
    always_comb begin
        div_req.go    = 1'b0;
        div_req.steps = tdr_pkg::DIV_STEPS_FRAC;
        div_rem0      = '0;
        div_num       = '0;
        div_den       = r_dabs;
        unique case (r_state)
            S_XF_DIV: begin
                div_req.go    = 1'b1;
                div_req.steps = tdr_pkg::DIV_STEPS_NDC;
                div_num       = {cmag, 16'h0000};
                div_den       = tdr_pkg::DIV_D_W'($unsigned(vrow[3]));
            end
            S_W0: begin
                div_req.go = !w0_full;
                div_rem0   = $unsigned(r_n0);
            end
            S_W1: begin
                div_req.go = !w1_full;
                div_rem0   = $unsigned(r_n1);
            end
            default: begin
                div_req.go = 1'b0;
            end
        endcase
    end

    // Depth map port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pix_addr;
        ram_wdata = depth;
        ram_re    = 1'b0;
        ram_raddr = pix_addr;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = tdr_pkg::DEPTH_FAR;
        end else if (r_state == S_Z4) begin
            ram_we = depth_less;
        end
        if (r_state == S_RD) begin
            ram_re    = 1'b1;
            ram_raddr = r_rd_addr;
        end else if (r_state == S_P5) begin
            ram_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_clr_item  <= 1'b0;
            r_vcnt      <= '0;
            r_out_valid <= 1'b0;
            r_cfg_w     <= tdr_pkg::CFG_W'(256);
            r_cfg_h     <= tdr_pkg::CFG_W'(256);
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tdr_pkg::CFG_IDX_WIDTH:  r_cfg_w <= i_cfg_data;
                    tdr_pkg::CFG_IDX_HEIGHT: r_cfg_h <= i_cfg_data;
                    default:                 r_cfg_w <= r_cfg_w;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == tdr_pkg::ADDR_W'(tdr_pkg::MAP_SIZE - 1)) begin
                        r_clr_item <= 1'b0;
                        r_state    <= r_clr_item ? S_EMIT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_res <= '0;
                        priority case (i_in_word.kind)
                            tdr_pkg::KIND_VERTEX: begin
                                if (r_vcnt != tdr_pkg::VTX_LAST) begin
                                    r_vtx[r_vcnt][0] <= i_in_word.clip_x;
                                    r_vtx[r_vcnt][1] <= i_in_word.clip_y;
                                    r_vtx[r_vcnt][2] <= i_in_word.clip_z;
                                    r_vtx[r_vcnt][3] <= i_in_word.clip_w;
                                    r_vcnt  <= r_vcnt + 1'b1;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_vcnt <= '0;
                                    r_res.triangle_done <= 1'b1;
                                    if (culled) begin
                                        r_res.triangle_culled <= 1'b1;
                                        r_state <= S_EMIT;
                                    end else begin
                                        r_vtx[2][0] <= i_in_word.clip_x;
                                        r_vtx[2][1] <= i_in_word.clip_y;
                                        r_vtx[2][2] <= i_in_word.clip_z;
                                        r_vtx[2][3] <= i_in_word.clip_w;
                                        r_wm1   <= tdr_pkg::XW'(wc - 1'b1);
                                        r_hm1   <= tdr_pkg::YW'(hc - 1'b1);
                                        r_k     <= '0;
                                        r_c     <= COMP_X;
                                        r_count <= '0;
                                        r_state <= S_XF_DIV;
                                    end
                                end
                            end
                            tdr_pkg::KIND_READ: begin
                                r_rd_addr <= tdr_pkg::ADDR_W'(
                                    32'(i_in_word.pixel_y) * tdr_pkg::MAP_WIDTH
                                    + 32'(i_in_word.pixel_x));
                                if (rd_inside) begin
                                    r_state <= S_RD;
                                end else begin
                                    r_res.depth_read <= tdr_pkg::DEPTH_FAR;
                                    r_state <= S_EMIT;
                                end
                            end
                            tdr_pkg::KIND_CLEAR: begin
                                r_clr      <= '0;
                                r_clr_item <= 1'b1;
                                r_state    <= S_CLEAR;
                            end
                            default: begin
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_RD: r_state <= S_RD2;
                S_RD2: begin
                    r_res.depth_read <= ram_rdata;
                    r_state <= S_EMIT;
                end
                S_XF_DIV: r_state <= S_XF_WAIT;
                S_XF_WAIT: begin
                    if (div_done) begin
                        if (r_c == COMP_Z) begin
                            r_nz[r_k] <= tdr_pkg::sat_word(comp[31], div_quot);
                            r_c <= COMP_X;
                            if (r_k == 2'd2) begin
                                r_state <= S_BOX;
                            end else begin
                                r_k     <= r_k + 1'b1;
                                r_state <= S_XF_DIV;
                            end
                        end else begin
                            r_ndc   <= tdr_pkg::sat_guard(comp[31], div_quot);
                            r_state <= S_XF_MUL;
                        end
                    end
                end
                S_XF_MUL: r_state <= S_XF_SCL;
                S_XF_SCL: begin
                    // Q.8 subpixel: drop nine bits of (1 + ndc) * (width - 1) for x, (1 - ndc) * (height - 1) for y
                    if (r_c == COMP_X) r_sx[r_k] <= tdr_pkg::CRD_W'(mul_p >>> 9);
                    else r_sy[r_k] <= tdr_pkg::CRD_W'(mul_p >>> 9);
                    r_c     <= r_c + 1'b1;
                    r_state <= S_XF_DIV;
                end
                S_BOX: begin
                    r_minx <= tdr_pkg::XW'(lox);
                    r_maxx <= tdr_pkg::XW'(hix);
                    r_miny <= tdr_pkg::YW'(loy);
                    r_maxy <= tdr_pkg::YW'(hiy);
                    r_box_empty <= (lox > hix) || (loy > hiy);
                    r_e0a <= tdr_pkg::EDG_W'(r_sy[1]) - tdr_pkg::EDG_W'(r_sy[2]);
                    r_e0b <= tdr_pkg::EDG_W'(r_sx[2]) - tdr_pkg::EDG_W'(r_sx[1]);
                    r_e1a <= tdr_pkg::EDG_W'(r_sy[2]) - tdr_pkg::EDG_W'(r_sy[0]);
                    r_e1b <= tdr_pkg::EDG_W'(r_sx[0]) - tdr_pkg::EDG_W'(r_sx[2]);
                    r_state <= S_DET1;
                end
                S_DET1: r_state <= S_DET2;
                S_DET2: begin
                    r_acc   <= tdr_pkg::ACC_W'(mul_p);
                    r_state <= S_DET3;
                end
                S_DET3: begin
                    r_dneg <= sum[tdr_pkg::ACC_W-1];
                    r_dabs <= sum[tdr_pkg::ACC_W-1] ? $unsigned(-sum) : $unsigned(sum);
                    r_px   <= r_minx;
                    r_py   <= r_miny;
                    // Degenerate triangle or empty box: nothing to draw
                    if (sum == '0 || r_box_empty) begin
                        r_res.pixels_written <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_P1;
                    end
                end
                S_P1: r_state <= S_P2;
                S_P2: begin
                    r_acc   <= tdr_pkg::ACC_W'(mul_p);
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_n0    <= sum;
                    r_state <= S_P4;
                end
                S_P4: begin
                    r_acc   <= tdr_pkg::ACC_W'(mul_p);
                    r_state <= S_P5;
                end
                S_P5: begin
                    r_n1    <= sum;
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    r_n0 <= n0s;
                    r_n1 <= n1s;
                    if (n0s < 0 || n1s < 0 || n2 < 0) r_state <= S_NEXT;
                    else r_state <= S_W0;
                end
                S_W0: begin
                    if (w0_full) begin
                        r_w0    <= tdr_pkg::WGT_W'(17'h1_0000);
                        r_state <= S_W1;
                    end else begin
                        r_state <= S_W0_WAIT;
                    end
                end
                S_W0_WAIT: begin
                    if (div_done) begin
                        r_w0    <= tdr_pkg::WGT_W'(div_quot);
                        r_state <= S_W1;
                    end
                end
                S_W1: begin
                    if (w1_full) begin
                        r_w1    <= tdr_pkg::WGT_W'(17'h1_0000);
                        r_state <= S_Z1;
                    end else begin
                        r_state <= S_W1_WAIT;
                    end
                end
                S_W1_WAIT: begin
                    if (div_done) begin
                        r_w1    <= tdr_pkg::WGT_W'(div_quot);
                        r_state <= S_Z1;
                    end
                end
                S_Z1: r_state <= S_Z2;
                S_Z2: begin
                    r_acc   <= tdr_pkg::ACC_W'(mul_p);
                    r_state <= S_Z3;
                end
                S_Z3: begin
                    r_acc   <= sum;
                    r_state <= S_Z4;
                end
                S_Z4: begin
                    if (depth_less && r_count != 17'h1_FFFF) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    // Advance across the row, then down
                    if (r_px == r_maxx) begin
                        r_px <= r_minx;
                        if (r_py == r_maxy) begin
                            r_res.pixels_written <= r_count;
                            r_state <= S_EMIT;
                        end else begin
                            r_py    <= r_py + 1'b1;
                            r_state <= S_P1;
                        end
                    end else begin
                        r_px    <= r_px + 1'b1;
                        r_state <= S_P1;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    tdr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    tdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_rem0  (div_rem0),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    tdr_ram #(
        .WIDTH (32),
        .DEPTH (tdr_pkg::MAP_SIZE)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    `TDR_ASSERT_IMPL(a_clear_far, ram_we && r_state == S_CLEAR, ram_wdata == tdr_pkg::DEPTH_FAR)
    `TDR_ASSERT_NEXT(a_accept_busy, in_acc, !o_in_ready)
    `TDR_ASSERT_IMPL(a_cull_done, o_out_valid && o_out_word.triangle_culled,
                     o_out_word.triangle_done)
    `TDR_ASSERT_IMPL(a_pix_in_box, r_state == S_P1,
                     r_px >= r_minx && r_px <= r_maxx && r_py >= r_miny && r_py <= r_maxy)

endmodule
`default_nettype wire

@@ bench/triangle_depth_rasterizer_top_tb.sv @@
// Self-checking bench for the shadow-map depth rasterizer: predictor, stimulus and checks.
`default_nettype none
module triangle_depth_rasterizer_top_tb;
    import tdr_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         RX_HOLD     = 3000;

    class depth_scoreboard;
        logic signed [31:0] depth_map [MAP_SIZE];
        logic signed [31:0] held_vtx [8];
        int unsigned        vtx_count;
        int unsigned        map_w_reg;
        int unsigned        map_h_reg;
        t_out_word          expected_q [$];
        int                 errors;
        int                 triangles;
        int                 pixels_total;

        function new();
            foreach (depth_map[i]) depth_map[i] = DEPTH_FAR;
            vtx_count = 0;
            map_w_reg = 256;
            map_h_reg = 256;
            errors = 0;
            triangles = 0;
            pixels_total = 0;
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] data);
            if (idx == CFG_IDX_WIDTH) map_w_reg = data;
            else map_h_reg = data;
        endfunction

        function longint fdiv(longint v, longint d);
            longint q;
            q = v / d;
            if (v % d != 0 && v < 0) q--;
            return q;
        endfunction

        function longint cdiv(longint v, longint d);
            longint q;
            q = v / d;
            if (v % d != 0 && v > 0) q++;
            return q;
        endfunction

        // floor(n * 2^16 / d), capped at 2^16 when n >= d, bit-serial so it stays exact
        function longint frac16(longint n, longint d);
            longint r, q;
            if (n >= d) return 65536;
            r = n;
            q = 0;
            for (int i = 0; i < 16; i++) begin
                r = r * 2;
                q = q * 2;
                if (r >= d) begin
                    r = r - d;
                    q = q + 1;
                end
            end
            return q;
        endfunction

        function void note_input(t_in_word w);
            t_out_word e;
            longint v [3][4];
            longint sx [3], sy [3], nz [3];
            longint wd, ht, nx, ny, mnx, mxx, mny, mxy, d;
            longint ppx, ppy, n0, n1, n2, dd, w0, w1, w2, depth;
            int cnt;
            bit culled;
            e = '0;
            case (w.kind)
                KIND_VERTEX: begin
                    if (vtx_count < 2) begin
                        held_vtx[vtx_count*4]   = w.clip_x;
                        held_vtx[vtx_count*4+1] = w.clip_y;
                        held_vtx[vtx_count*4+2] = w.clip_z;
                        held_vtx[vtx_count*4+3] = w.clip_w;
                        vtx_count++;
                    end else begin
                        for (int k = 0; k < 2; k++)
                            for (int j = 0; j < 4; j++) v[k][j] = held_vtx[k*4+j];
                        v[2][0] = w.clip_x;
                        v[2][1] = w.clip_y;
                        v[2][2] = w.clip_z;
                        v[2][3] = w.clip_w;
                        vtx_count = 0;
                        culled = 0;
                        for (int k = 0; k < 3; k++) if (v[k][3] <= 0) culled = 1;
                        e.triangle_done = 1;
                        triangles++;
                        cnt = 0;
                        if (culled) e.triangle_culled = 1;
                        else begin
                            wd = map_w_reg < 1 ? 1 : (map_w_reg > MAP_WIDTH ? MAP_WIDTH : map_w_reg);
                            ht = map_h_reg < 1 ? 1 : (map_h_reg > MAP_HEIGHT ? MAP_HEIGHT : map_h_reg);
                            for (int k = 0; k < 3; k++) begin
                                nx = (v[k][0] * 65536) / v[k][3];
                                ny = (v[k][1] * 65536) / v[k][3];
                                nz[k] = (v[k][2] * 65536) / v[k][3];
                                if (nx < -4194304) nx = -4194304;
                                if (nx > 4194303) nx = 4194303;
                                if (ny < -4194304) ny = -4194304;
                                if (ny > 4194303) ny = 4194303;
                                if (nz[k] < -64'sd2147483648) nz[k] = -64'sd2147483648;
                                if (nz[k] > 64'sd2147483647) nz[k] = 64'sd2147483647;
                                sx[k] = fdiv((nx + 65536) * (wd - 1), 512);
                                sy[k] = fdiv((65536 - ny) * (ht - 1), 512);
                            end
                            mnx = sx[0]; mxx = sx[0]; mny = sy[0]; mxy = sy[0];
                            for (int k = 1; k < 3; k++) begin
                                if (sx[k] < mnx) mnx = sx[k];
                                if (sx[k] > mxx) mxx = sx[k];
                                if (sy[k] < mny) mny = sy[k];
                                if (sy[k] > mxy) mxy = sy[k];
                            end
                            mnx = fdiv(mnx, 256); if (mnx < 0) mnx = 0;
                            mny = fdiv(mny, 256); if (mny < 0) mny = 0;
                            mxx = cdiv(mxx, 256); if (mxx > wd - 1) mxx = wd - 1;
                            mxy = cdiv(mxy, 256); if (mxy > ht - 1) mxy = ht - 1;
                            d = (sy[1] - sy[2]) * (sx[0] - sx[2]) + (sx[2] - sx[1]) * (sy[0] - sy[2]);
                            // degenerate triangle covers nothing
                            if (d != 0) begin
                                for (longint py = mny; py <= mxy; py++) begin
                                    for (longint px = mnx; px <= mxx; px++) begin
                                        ppx = px * 256 - sx[2];
                                        ppy = py * 256 - sy[2];
                                        n0 = (sy[1] - sy[2]) * ppx + (sx[2] - sx[1]) * ppy;
                                        n1 = (sy[2] - sy[0]) * ppx + (sx[0] - sx[2]) * ppy;
                                        dd = d;
                                        if (dd < 0) begin
                                            dd = -dd; n0 = -n0; n1 = -n1;
                                        end
                                        n2 = dd - n0 - n1;
                                        if (n0 >= 0 && n1 >= 0 && n2 >= 0) begin
                                            w0 = frac16(n0, dd);
                                            w1 = frac16(n1, dd);
                                            w2 = 65536 - w0 - w1;
                                            depth = fdiv(nz[0]*w0 + nz[1]*w1 + nz[2]*w2, 65536);
                                            if (depth < longint'(depth_map[py*MAP_WIDTH + px])) begin
                                                depth_map[py*MAP_WIDTH + px] = depth;
                                                if (cnt < 131071) cnt++;
                                            end
                                        end
                                    end
                                end
                            end
                            e.pixels_written = cnt;
                            pixels_total += cnt;
                        end
                    end
                end
                KIND_READ: e.depth_read = depth_map[int'(w.pixel_y) * MAP_WIDTH + int'(w.pixel_x)];
                KIND_CLEAR: foreach (depth_map[i]) depth_map[i] = DEPTH_FAR;
                default: ;
            endcase
            expected_q.push_back(e);
        endfunction

        function void check(t_out_word got);
            t_out_word e;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: %h", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.depth_read !== e.depth_read) begin
                $error("depth_read expected %0d actual %0d", e.depth_read, got.depth_read);
                errors++;
            end
            if (got.pixels_written !== e.pixels_written) begin
                $error("pixels_written expected %0d actual %0d",
                       e.pixels_written, got.pixels_written);
                errors++;
            end
            if (got.triangle_culled !== e.triangle_culled) begin
                $error("triangle_culled expected %0d actual %0d",
                       e.triangle_culled, got.triangle_culled);
                errors++;
            end
            if (got.triangle_done !== e.triangle_done) begin
                $error("triangle_done expected %0d actual %0d",
                       e.triangle_done, got.triangle_done);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_word            i_in_word;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_word           o_out_word;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;

    depth_scoreboard sb;
    bit  quiet;
    bit  hold_req;
    int  words_sent;
    int  clears_left;

    triangle_depth_rasterizer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("triangle_depth_rasterizer_top_tb: errors");
        $finish;
    end

    function automatic t_in_word noise_word();
        t_in_word r;
        r.kind    = $urandom_range(0, 3);
        r.clip_x  = $urandom;
        r.clip_y  = $urandom;
        r.clip_z  = $urandom;
        r.clip_w  = $urandom;
        r.pixel_x = $urandom;
        r.pixel_y = $urandom;
        return r;
    endfunction

    function automatic t_in_word vtx(int x, int y, int z, int w);
        t_in_word r;
        r = noise_word();
        r.kind   = KIND_VERTEX;
        r.clip_x = x;
        r.clip_y = y;
        r.clip_z = z;
        r.clip_w = w;
        return r;
    endfunction

    function automatic t_in_word read_at(int x, int y);
        t_in_word r;
        r = noise_word();
        r.kind    = KIND_READ;
        r.pixel_x = x;
        r.pixel_y = y;
        return r;
    endfunction

    // Keep valid high across back-to-back words; drop it only for a gap.
    task automatic send(t_in_word w);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_word  <= w;
        i_in_valid <= 1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [CFG_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Local triangles keep the bounding box small on wide maps.
    task automatic send_triangle(bit local_only);
        int mode, cx, cy, w;
        mode = local_only ? $urandom_range(0, 6) : $urandom_range(0, 9);
        cx = $urandom_range(0, 131072) - 65536;
        cy = $urandom_range(0, 131072) - 65536;
        for (int k = 0; k < 3; k++) begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(32768, 131072) : 65536;
            if (mode == 6 && k == 2) w = -$urandom_range(0, 65536);
            case (mode)
                7: send(vtx($urandom_range(0, 524288) - 262144,
                            $urandom_range(0, 524288) - 262144, $urandom, 65536));
                8: send(vtx($urandom, $urandom, $urandom, $urandom_range(1, 32'h7fffffff)));
                9: send(vtx(cx + k * 1000, cy + k * 2000, $urandom, 65536));
                default: send(vtx(cx + $urandom_range(0, 6000) - 3000,
                                  cy + $urandom_range(0, 6000) - 3000, $urandom, w));
            endcase
        end
    endtask

    task automatic run_phase(int n, bit local_only, int wd, int ht);
        int count, r;
        t_in_word x;
        count = 0;
        while (count < n) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_triangle(local_only);
                count += 3;
            end else if (r < 80) begin
                if ($urandom_range(0, 1)) send(read_at($urandom_range(0, wd - 1),
                                                       $urandom_range(0, ht - 1)));
                else send(read_at($urandom_range(0, 255), $urandom_range(0, 255)));
                count++;
            end else if (r < 92) begin
                x = noise_word();
                x.kind = KIND_VERTEX;
                if (local_only) x.clip_w = -$urandom_range(0, 1000);
                send(x);
                count++;
            end else if (r < 99 || clears_left == 0) begin
                x = noise_word();
                x.kind = KIND_UNUSED;
                send(x);
                count++;
            end else begin
                x = noise_word();
                x.kind = KIND_CLEAR;
                send(x);
                clears_left--;
                count++;
            end
        end
    endtask

    initial begin
        i_out_ready = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_out_ready <= 0;
                repeat (RX_HOLD) @(negedge i_clk);
            end else if (!quiet) begin
                i_out_ready <= 0;
                repeat ($urandom_range(0, 19)) @(negedge i_clk);
            end
            i_out_ready <= 1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check(o_out_word);
            @(negedge i_clk);
        end
    end

    initial begin
        int wset [9], hset [9], wd, ht;
        t_in_word x;
        wset = '{4, 1, 0, 7, 511, 2, 5, 256, 8};
        hset = '{4, 1, 3, 2, 2, 300, 8, 256, 6};
        sb = new();
        quiet = 0;
        hold_req = 0;
        words_sent = 0;
        clears_left = 2;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_word = '0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1;

        // directed words on the full map
        send(read_at(0, 0));
        send(read_at(255, 255));
        x = noise_word();
        x.kind = KIND_UNUSED;
        send(x);
        send(vtx(-3000, -3000, 1000, 65536));
        send(vtx(3000, -3000, 2000, 65536));
        send(vtx(0, 3000, -5000, 65536));
        send(read_at(127, 127));
        send(vtx(-2000, 0, 500, 65536));
        send(read_at(127, 128));
        send(vtx(2000, 0, 600, 65536));
        x = noise_word();
        x.kind = KIND_CLEAR;
        send(x);
        send(vtx(0, 2500, 700, 65536));
        send(read_at(127, 127));
        send(vtx(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0));
        send(vtx(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        send(vtx(0, 0, 0, 32'h7fff_ffff));
        for (int k = 0; k < 3; k++) send(vtx(1000, 1000, 42, 65536));
        send(vtx(0, 0, 32'h7fff_ffff, 1));
        send(vtx(3000, 0, 32'h8000_0000, 65536));
        send(vtx(0, 3000, 100, 65536));
        send(read_at(128, 127));

        for (int p = 0; p < 9; p++) begin
            drain();
            write_cfg(CFG_IDX_WIDTH, wset[p]);
            write_cfg(CFG_IDX_HEIGHT, hset[p]);
            wd = wset[p] < 1 ? 1 : (wset[p] > MAP_WIDTH ? MAP_WIDTH : wset[p]);
            ht = hset[p] < 1 ? 1 : (hset[p] > MAP_HEIGHT ? MAP_HEIGHT : hset[p]);
            quiet = (p % 3 == 2);
            // stall the output long enough to back the block up
            if (p == 1) hold_req = 1;
            run_phase(140, wd * ht > 64, wd, ht);
        end
        drain();
        $display("sent %0d words over 9 map sizes; %0d triangles closed, %0d depth writes",
                 words_sent, sb.triangles, sb.pixels_total);
        if (sb.errors == 0) $display("triangle_depth_rasterizer_top_tb: clean");
        else $display("triangle_depth_rasterizer_top_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
